// ----- rtl/u2s_pkg.sv -----
// Shared types, codes and constants of the UTF-16 to single-byte converter.
`default_nettype none

package u2s_pkg;

  localparam int PAGE_COUNT_DEF       = 256;
  localparam int BYTE_TABLE_DEPTH_DEF = 65536;
  localparam int COUNT_BITS_DEF       = 24;

  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int FIELD_CW  = 24;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int PUSH_MAX   = 3;

  localparam logic [1:0] KIND_UNIT = 2'd0;
  localparam logic [1:0] KIND_PAGE = 2'd1;
  localparam logic [1:0] KIND_BYTE = 2'd2;

  localparam logic [1:0] MODE_FLAG = 2'd0;
  localparam logic [1:0] MODE_SKIP = 2'd1;
  localparam logic [1:0] MODE_FILL = 2'd2;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_INV = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_INITIAL  = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;
  localparam logic [1:0] REG_RBYTE    = 2'd3;

  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
  localparam logic [15:0] LOW_BYTE_MASK   = 16'h00FF;

  typedef struct packed {
    logic [FIELD_CW-1:0] capacity;
    logic [FIELD_CW-1:0] initial_count;
    logic [1:0]          mode;
    logic [7:0]          rbyte;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] unit;
    logic        last;
    logic [7:0]  code;
  } unit_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                stream_done;
    logic [1:0]          status;
    logic [FIELD_CW-1:0] final_count;
  } res_t;

  typedef struct packed {
    logic [1:0]          n;
    res_t [PUSH_MAX-1:0] ent;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/u2s_cfg_regs.sv -----
// APB-style configuration register file of the converter.
`default_nettype none

module u2s_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [u2s_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [u2s_pkg::CFG_DW-1:0]   pwdata,
  output logic      [u2s_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready,
  output u2s_pkg::cfg_t                     cfg
);
  import u2s_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CAPACITY: cfg_r.capacity      <= pwdata[FIELD_CW-1:0];
        REG_INITIAL:  cfg_r.initial_count <= pwdata[FIELD_CW-1:0];
        REG_MODE:     cfg_r.mode          <= pwdata[1:0];
        REG_RBYTE:    cfg_r.rbyte         <= pwdata[7:0];
        default:      cfg_r               <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAPACITY: prdata = CFG_DW'(cfg_r.capacity);
      REG_INITIAL:  prdata = CFG_DW'(cfg_r.initial_count);
      REG_MODE:     prdata = CFG_DW'(cfg_r.mode);
      REG_RBYTE:    prdata = CFG_DW'(cfg_r.rbyte);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/u2s_lookup.sv -----
// Two-stage table lookup: page memory read, then byte memory read.
`default_nettype none

module u2s_lookup #(
  parameter int PAGE_COUNT       = u2s_pkg::PAGE_COUNT_DEF,
  parameter int BYTE_TABLE_DEPTH = u2s_pkg::BYTE_TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        in_take,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] unit,
  input  wire logic [15:0] addr,
  input  wire logic [7:0]  data,
  input  wire logic        last,
  output u2s_pkg::unit_t   s2
);
  import u2s_pkg::*;

  localparam int PAGE_AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int BYTE_AW = $clog2(BYTE_TABLE_DEPTH);

  logic [7:0] page_mem [PAGE_COUNT];
  logic [7:0] byte_mem [BYTE_TABLE_DEPTH];

  logic        s1_valid_r;
  logic [1:0]  s1_kind_r;
  logic [15:0] s1_unit_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic        s1_last_r;
  logic        s1_pg_oor_r;
  logic [7:0]  page_rd_r;

  logic        s2_valid_r;
  logic [15:0] s2_unit_r;
  logic        s2_last_r;
  logic        s2_oor_r;
  logic [7:0]  byte_rd_r;

  logic [7:0]  hi_byte;
  logic        pg_oor;
  logic        page_wr;
  logic [7:0]  s1_page;
  logic [15:0] s1_idx;
  logic        byte_oor;
  logic        byte_wr;

  assign hi_byte  = unit[15:8];
  assign pg_oor   = {1'b0, hi_byte} >= 9'(PAGE_COUNT);
  assign page_wr  = adv && in_take && (kind == KIND_PAGE) && ({1'b0, addr} < 17'(PAGE_COUNT));
  assign s1_page  = s1_pg_oor_r ? 8'd0 : page_rd_r;
  assign s1_idx   = {s1_page, 8'(s1_unit_r & LOW_BYTE_MASK)};
  assign byte_oor = {1'b0, s1_idx} >= 17'(BYTE_TABLE_DEPTH);
  assign byte_wr  = adv && s1_valid_r && (s1_kind_r == KIND_BYTE) &&
                    ({1'b0, s1_addr_r} < 17'(BYTE_TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (page_wr) begin
      page_mem[addr[PAGE_AW-1:0]] <= data;
    end
    if (adv) begin
      page_rd_r <= page_mem[hi_byte[PAGE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (byte_wr) begin
      byte_mem[s1_addr_r[BYTE_AW-1:0]] <= s1_data_r;
    end
    if (adv) begin
      byte_rd_r <= byte_mem[s1_idx[BYTE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_take;
      s2_valid_r <= s1_valid_r && (s1_kind_r == KIND_UNIT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r   <= kind;
      s1_unit_r   <= unit;
      s1_addr_r   <= addr;
      s1_data_r   <= data;
      s1_last_r   <= last;
      s1_pg_oor_r <= pg_oor;
      s2_unit_r   <= s1_unit_r;
      s2_last_r   <= s1_last_r;
      s2_oor_r    <= byte_oor;
    end
  end

  assign s2.valid = s2_valid_r;
  assign s2.unit  = s2_unit_r;
  assign s2.last  = s2_last_r;
  assign s2.code  = s2_oor_r ? 8'd0 : byte_rd_r;

endmodule

`default_nettype wire

// ----- rtl/u2s_stream.sv -----
// Stream state and per-unit decision logic producing up to three results.
`default_nettype none

module u2s_stream #(
  parameter int COUNT_BITS = u2s_pkg::COUNT_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire u2s_pkg::cfg_t   cfg,
  input  wire u2s_pkg::unit_t  s2,
  output u2s_pkg::push_t       push
);
  import u2s_pkg::*;

  localparam int CW = COUNT_BITS;

  logic          in_stream_r, pend_r, err_r, ovf_r;
  logic [CW-1:0] count_r;

  logic          take;
  logic [CW-1:0] cap, cnt_base, p1, p2, cnt_a, cnt_a_p1, cnt_fin;
  logic          pend_base, err_base, ovf_base;
  logic          room0, room1, room_a, fill_en;
  logic          is_high, is_low;
  logic          a_act, a_emit, a_err, a_done;
  logic          b_act, b_lone, b_pend, b_plain, b_bad, b_inv, b_fill, b_err;
  logic          b_conv, b_byte, b_ovf;
  logic          ovf_fin, err_fin, pend_fin;
  logic          v0, v1, v2;
  res_t          e0, e1, e2;

  assign take      = adv && s2.valid;
  assign cap       = CW'(cfg.capacity);
  assign cnt_base  = in_stream_r ? count_r : CW'(cfg.initial_count);
  assign pend_base = in_stream_r && pend_r;
  assign err_base  = in_stream_r && err_r;
  assign ovf_base  = in_stream_r && ovf_r;
  assign p1        = cnt_base + CW'(1);
  assign p2        = cnt_base + CW'(2);
  assign room0     = cnt_base < cap;
  assign room1     = p1 < cap;
  assign fill_en   = (cfg.mode == MODE_FILL) && (cfg.rbyte != 8'd0);

  assign is_high = (s2.unit >= HIGH_SURR_FIRST) && (s2.unit <= HIGH_SURR_LAST);
  assign is_low  = (s2.unit >= LOW_SURR_FIRST) && (s2.unit <= LOW_SURR_LAST);

  assign a_act    = !ovf_base && pend_base;
  assign a_emit   = a_act && fill_en && room0;
  assign a_err    = a_act && is_low && (cfg.mode == MODE_FLAG);
  assign a_done   = a_act && is_low;
  assign cnt_a    = a_emit ? p1 : cnt_base;
  assign cnt_a_p1 = a_emit ? p2 : p1;
  assign room_a   = a_emit ? room1 : room0;

  assign b_act   = !ovf_base && !a_done;
  assign b_lone  = b_act && ((is_high && s2.last) || is_low);
  assign b_pend  = b_act && is_high && !s2.last;
  assign b_plain = b_act && !is_high && !is_low;
  assign b_bad   = b_plain && (s2.code == 8'd0) && (s2.unit != 16'd0);
  assign b_inv   = b_lone || b_bad;
  assign b_fill  = b_inv && fill_en && room_a;
  assign b_err   = b_bad && (cfg.mode == MODE_FLAG);
  assign b_conv  = b_plain && !b_bad;
  assign b_byte  = b_conv && room_a;
  assign b_ovf   = b_conv && !room_a;

  assign cnt_fin  = (b_fill || b_byte) ? cnt_a_p1 : cnt_a;
  assign ovf_fin  = ovf_base || b_ovf;
  assign err_fin  = err_base || a_err || b_err;
  assign pend_fin = ovf_base ? pend_base : b_pend;

  always_comb begin
    e0 = '0;
    e0.out_byte   = cfg.rbyte;
    e0.byte_valid = 1'b1;
    e1 = '0;
    e1.out_byte   = b_fill ? cfg.rbyte : s2.code;
    e1.byte_valid = 1'b1;
    e2 = '0;
    e2.stream_done = 1'b1;
    if (ovf_fin) begin
      e2.status      = STAT_OVF;
      e2.final_count = FIELD_CW'(cnt_fin);
    end else if (err_fin) begin
      e2.status      = STAT_INV;
      e2.final_count = '0;
    end else begin
      e2.status      = STAT_OK;
      e2.final_count = FIELD_CW'(cnt_fin);
    end
  end

  assign v0 = take && a_emit;
  assign v1 = take && (b_fill || b_byte);
  assign v2 = take && s2.last;

  always_comb begin
    push.n      = 2'(v0) + 2'(v1) + 2'(v2);
    push.ent[0] = v0 ? e0 : (v1 ? e1 : e2);
    push.ent[1] = (v0 && v1) ? e1 : e2;
    push.ent[2] = e2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_stream_r <= 1'b0;
      pend_r      <= 1'b0;
      err_r       <= 1'b0;
      ovf_r       <= 1'b0;
      count_r     <= '0;
    end else if (take) begin
      count_r <= cnt_fin;
      if (s2.last) begin
        in_stream_r <= 1'b0;
        pend_r      <= 1'b0;
        err_r       <= 1'b0;
        ovf_r       <= 1'b0;
      end else begin
        in_stream_r <= 1'b1;
        pend_r      <= pend_fin;
        err_r       <= err_fin;
        ovf_r       <= ovf_fin;
      end
    end
  end

  a_no_byte_after_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ovf_base) |-> !(v0 || v1))
    else $error("byte result produced after overflow");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !s2.last) |=> (count_r == $past(cnt_base) + CW'($past(v0)) + CW'($past(v1))))
    else $error("byte count does not match emitted bytes");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s2.last) |=> !in_stream_r && !pend_r && !ovf_r && !err_r)
    else $error("stream state not cleared at stream end");

endmodule

`default_nettype wire

// ----- rtl/u2s_out_fifo.sv -----
// Result queue that takes up to three results per cycle and hands out one.
`default_nettype none

module u2s_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire u2s_pkg::push_t push,
  input  wire logic           out_ready,
  output logic                out_valid,
  output u2s_pkg::res_t       head,
  output logic                space_ok
);
  import u2s_pkg::*;

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               pop;

  assign out_valid = count_r != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rd_ptr_r];
  assign space_ok  = (count_r + (FIFO_AW+1)'(PUSH_MAX)) <= (FIFO_AW+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (2'(k) < push.n) begin
        mem_r[wr_ptr_r + FIFO_AW'(k)] <= push.ent[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push.n);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      count_r  <= count_r + (FIFO_AW+1)'(push.n) - (FIFO_AW+1)'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overrun");

  a_push_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> space_ok)
    else $error("results pushed without reserved space");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd0 && !pop) |=> $stable(count_r))
    else $error("queue level changed without a transaction");

endmodule

`default_nettype wire

// ----- rtl/utf16_to_single_byte_converter.sv -----
// Top level of the UTF-16 to single-byte converter.
//
// The input channel carries one transaction per item: a code unit to convert,
// or a write into the page table or the byte table. Table writes give no
// results. A code unit gives zero, one or two byte results, and the unit
// marked last adds a status result that closes the stream.
// Results leave through a valid/ready channel in order, one per cycle while the receiver is ready.
// A code unit passes the page memory read, the byte memory read and the
// decision stage; its results are queued before they are offered.
// One item is accepted per cycle as long as the eight-entry result queue has
// room for three more results; the output rate of one result per cycle is
// therefore what bounds throughput when units expand into several results.
// When the receiver stalls, the queue fills and the input ready drops; no
// result is lost. Reset clears the stream state, the pipeline valids and the
// queue; the table contents are undefined until written.
// The user must write configuration through the APB-style port while the block idles; the block does not enforce it.
`default_nettype none

module utf16_to_single_byte_converter #(
  parameter int PAGE_COUNT       = u2s_pkg::PAGE_COUNT_DEF,
  parameter int BYTE_TABLE_DEPTH = u2s_pkg::BYTE_TABLE_DEPTH_DEF,
  parameter int COUNT_BITS       = u2s_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_kind,
  input  wire logic [15:0]                        in_code_unit,
  input  wire logic [15:0]                        in_table_addr,
  input  wire logic [7:0]                         in_table_data,
  input  wire logic                               in_last_unit,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_byte,
  output logic                                    out_byte_valid,
  output logic                                    out_stream_done,
  output logic [1:0]                              out_status,
  output logic [u2s_pkg::FIELD_CW-1:0]            out_final_count,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [u2s_pkg::CFG_AW-1:0]         paddr,
  input  wire logic [u2s_pkg::CFG_DW-1:0]         pwdata,
  output logic      [u2s_pkg::CFG_DW-1:0]         prdata,
  output logic                                    pready
);
  import u2s_pkg::*;

  cfg_t  cfg;
  unit_t s2;
  push_t push;
  res_t  head;
  logic  adv;

  assign in_ready = adv;

  u2s_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  u2s_lookup #(
    .PAGE_COUNT       (PAGE_COUNT),
    .BYTE_TABLE_DEPTH (BYTE_TABLE_DEPTH)
  ) u_lookup (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_take (in_valid),
    .kind    (in_kind),
    .unit    (in_code_unit),
    .addr    (in_table_addr),
    .data    (in_table_data),
    .last    (in_last_unit),
    .s2      (s2)
  );

  u2s_stream #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stream (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg),
    .s2    (s2),
    .push  (push)
  );

  u2s_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .space_ok  (adv)
  );

  assign out_byte        = head.out_byte;
  assign out_byte_valid  = head.byte_valid;
  assign out_stream_done = head.stream_done;
  assign out_status      = head.status;
  assign out_final_count = head.final_count;

endmodule

`default_nettype wire

// ----- dv/tb_utf16_to_single_byte_converter.sv -----
// Self-checking testbench of the UTF-16 to single-byte converter with its own prediction.
`default_nettype none

module tb_utf16_to_single_byte_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import u2s_pkg::*;

  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         HOLD_CYCLES = 150;
  localparam int         SETTLE      = 12;
  localparam int         LIMIT       = 200000;
  localparam int         SHOW_MAX    = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code_unit;
    logic [15:0] table_addr;
    logic [7:0]  table_data;
    logic        last_unit;
  } conv_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_kind = '0;
  logic [15:0]         in_code_unit = '0;
  logic [15:0]         in_table_addr = '0;
  logic [7:0]          in_table_data = '0;
  logic                in_last_unit = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_byte;
  logic                out_byte_valid;
  logic                out_stream_done;
  logic [1:0]          out_status;
  logic [FIELD_CW-1:0] out_final_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  utf16_to_single_byte_converter u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_code_unit    (in_code_unit),
    .in_table_addr   (in_table_addr),
    .in_table_data   (in_table_data),
    .in_last_unit    (in_last_unit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_stream_done (out_stream_done),
    .out_status      (out_status),
    .out_final_count (out_final_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  conv_item_t    unit_feed_q[$];
  res_t          expected_codes[$];
  conv_item_t    cur_item;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_seq = 0;
  int            hold_seen = 0;
  int            hold_cnt = 0;
  int            mismatches = 0;
  int unsigned   cycles = 0;

  // Predicted converter state and registers.
  logic [7:0]    m_page [256];
  logic [7:0]    m_bytes [65536];
  logic          m_pend = 1'b0;
  logic          m_err = 1'b0;
  logic          m_ovf = 1'b0;
  logic          m_open = 1'b0;
  logic [23:0]   m_count = '0;
  logic [23:0]   m_cap = '0;
  logic [23:0]   m_init = '0;
  logic [1:0]    m_mode = MODE_FLAG;
  logic [7:0]    m_rbyte = '0;

  // Stimulus bookkeeping: which table entries have been written so far.
  logic [7:0]    g_page [256];
  bit            g_page_set [256];
  bit            g_byte_set [65536];
  logic [15:0]   hot_units[$];

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic push_code(input logic [7:0] b);
    res_t r;
    r = '0;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    expected_codes.push_back(r);
  endtask

  task automatic on_bad_unit(input bit flaggable);
    if (m_mode == MODE_FLAG) begin
      if (flaggable) m_err = 1'b1;
    end else if (m_mode == MODE_FILL && m_rbyte != 8'h00) begin
      if (m_count < m_cap) begin
        push_code(m_rbyte);
        m_count = m_count + 24'd1;
      end
    end
  endtask

  task automatic convert_item(input conv_item_t it);
    logic [7:0]  pg;
    logic [7:0]  code;
    logic [15:0] u;
    bit          is_hi;
    bit          is_lo;
    bit          paired;
    res_t        st;
    u = it.code_unit;
    case (it.kind)
      KIND_PAGE: begin
        if (it.table_addr < PAGE_COUNT_DEF) m_page[it.table_addr[7:0]] = it.table_data;
      end
      KIND_BYTE: begin
        m_bytes[it.table_addr] = it.table_data;
      end
      KIND_UNIT: begin
        if (!m_open) begin
          m_open = 1'b1;
          m_count = m_init;
          m_pend = 1'b0;
          m_err = 1'b0;
          m_ovf = 1'b0;
        end
        if (!m_ovf) begin
          is_hi = (u >= HIGH_SURR_FIRST && u <= HIGH_SURR_LAST);
          is_lo = (u >= LOW_SURR_FIRST && u <= LOW_SURR_LAST);
          paired = 1'b0;
          if (m_pend) begin
            m_pend = 1'b0;
            if (is_lo) begin
              on_bad_unit(1'b1);
              paired = 1'b1;
            end else begin
              on_bad_unit(1'b0);
            end
          end
          if (!paired) begin
            if (is_hi) begin
              if (it.last_unit) on_bad_unit(1'b0);
              else m_pend = 1'b1;
            end else if (is_lo) begin
              on_bad_unit(1'b0);
            end else begin
              pg = m_page[u[15:8]];
              code = m_bytes[{pg, u[7:0]}];
              if (code == 8'h00 && u != 16'h0000) begin
                on_bad_unit(1'b1);
              end else if (m_count < m_cap) begin
                push_code(code);
                m_count = m_count + 24'd1;
              end else begin
                m_ovf = 1'b1;
              end
            end
          end
        end
        if (it.last_unit) begin
          st = '0;
          st.stream_done = 1'b1;
          if (m_ovf) begin
            st.status = STAT_OVF;
            st.final_count = m_count;
          end else if (m_err) begin
            st.status = STAT_INV;
          end else begin
            st.status = STAT_OK;
            st.final_count = m_count;
          end
          expected_codes.push_back(st);
          m_open = 1'b0;
          m_pend = 1'b0;
          m_err = 1'b0;
          m_ovf = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) convert_item(cur_item);
      if (!in_valid || in_ready) begin
        if (unit_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = unit_feed_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_item.kind;
          in_code_unit <= cur_item.code_unit;
          in_table_addr <= cur_item.table_addr;
          in_table_data <= cur_item.table_data;
          in_last_unit <= cur_item.last_unit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      out_ready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_cnt <= 0;
        hold_seen <= hold_seq;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_byte, out_byte_valid, out_stream_done, out_status, out_final_count};
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display({"%0t: unexpected transaction: expected none, ",
                    "got byte=%h bv=%b done=%b st=%0d cnt=%h"},
                   $time, got.out_byte, got.byte_valid, got.stream_done, got.status,
                   got.final_count);
      end else begin
        want = expected_codes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display({"%0t: mismatch: expected byte=%h bv=%b done=%b st=%0d cnt=%h, ",
                      "got byte=%h bv=%b done=%b st=%0d cnt=%h"},
                     $time, want.out_byte, want.byte_valid, want.stream_done, want.status,
                     want.final_count, got.out_byte, got.byte_valid, got.stream_done,
                     got.status, got.final_count);
        end
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {8'h00, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CAPACITY: m_cap = val;
      REG_INITIAL:  m_init = val;
      REG_MODE:     m_mode = val[1:0];
      REG_RBYTE:    m_rbyte = val[7:0];
      default: begin
      end
    endcase
  endtask

  task automatic write_regs(input logic [23:0] cap, input logic [23:0] init,
                            input logic [1:0] mode, input logic [7:0] rb);
    cfg_write(REG_CAPACITY, cap);
    cfg_write(REG_INITIAL, init);
    cfg_write(REG_MODE, {22'd0, mode});
    cfg_write(REG_RBYTE, {16'd0, rb});
    @(negedge clk);
  endtask

  task automatic feed(input logic [1:0] k, input logic [15:0] u, input logic [15:0] a,
                      input logic [7:0] d, input logic l);
    conv_item_t it;
    it.kind = k;
    it.code_unit = u;
    it.table_addr = a;
    it.table_data = d;
    it.last_unit = l;
    unit_feed_q.push_back(it);
  endtask

  task automatic claim_page(input logic [7:0] hi);
    if (!g_page_set[hi]) begin
      g_page[hi] = 8'($urandom_range(255));
      g_page_set[hi] = 1'b1;
      feed(KIND_PAGE, 16'($urandom), {8'h00, hi}, g_page[hi], 1'($urandom_range(1)));
    end
  endtask

  task automatic set_code(input logic [15:0] u, input logic [7:0] code);
    claim_page(u[15:8]);
    g_byte_set[{g_page[u[15:8]], u[7:0]}] = 1'b1;
    feed(KIND_BYTE, 16'($urandom), {g_page[u[15:8]], u[7:0]}, code, 1'($urandom_range(1)));
  endtask

  task automatic send_unit(input logic [15:0] u, input logic l);
    logic [7:0] code;
    claim_page(u[15:8]);
    if (!g_byte_set[{g_page[u[15:8]], u[7:0]}]) begin
      code = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      set_code(u, code);
    end
    feed(KIND_UNIT, u, 16'($urandom), 8'($urandom), l);
    if (u < HIGH_SURR_FIRST || u > LOW_SURR_LAST) hot_units.push_back(u);
  endtask

  task automatic noise_item();
    case ($urandom_range(2))
      0: feed(KIND_NONE, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
      1: feed(KIND_PAGE, 16'($urandom), 16'($urandom_range(256, 65535)), 8'($urandom),
              1'($urandom_range(1)));
      default: begin
        if (hot_units.size() != 0)
          set_code(hot_units[$urandom_range(hot_units.size() - 1)], 8'($urandom));
      end
    endcase
  endtask

  task automatic random_stream(inout int units);
    int          len;
    int          r;
    bit          want_low;
    logic [15:0] u;
    len = $urandom_range(1, 8);
    want_low = 1'b0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) noise_item();
      r = $urandom_range(99);
      if (want_low) begin
        u = LOW_SURR_FIRST | 16'($urandom_range(1023));
        want_low = 1'b0;
      end else if (r < 45 && hot_units.size() != 0) begin
        u = hot_units[$urandom_range(hot_units.size() - 1)];
      end else if (r < 65) begin
        u = 16'($urandom);
      end else if (r < 80) begin
        u = HIGH_SURR_FIRST | 16'($urandom_range(1023));
        want_low = 1'b1;
      end else if (r < 90) begin
        u = LOW_SURR_FIRST | 16'($urandom_range(1023));
      end else begin
        u = HIGH_SURR_FIRST | 16'($urandom_range(1023));
      end
      send_unit(u, i == len - 1);
      units++;
    end
  endtask

  task automatic random_setup();
    logic [23:0] cap;
    logic [23:0] init;
    int          r;
    r = $urandom_range(9);
    if (r == 0) cap = 24'd0;
    else if (r < 3) cap = 24'hFFFFFF;
    else cap = 24'($urandom_range(12));
    if (cap == 24'hFFFFFF)
      init = $urandom_range(1) ? 24'($urandom) : 24'hFFFFFF - 24'($urandom_range(6));
    else
      init = 24'($urandom_range(cap + 3));
    write_regs(cap, init, 2'($urandom_range(3)),
               ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
  endtask

  task automatic drain();
    do @(negedge clk);
    while (unit_feed_q.size() != 0 || in_valid || expected_codes.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int units;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill mode with plenty of room: unit zero, the top unit, surrogates.
    write_regs(24'hFFFFFF, 24'h000000, MODE_FILL, 8'hFF);
    set_code(16'h0000, 8'h00);
    set_code(16'hFFFF, 8'hA5);
    set_code(16'h0041, 8'h00);
    feed(KIND_PAGE, 16'hFFFF, 16'h0100, 8'hFF, 1'b1);
    feed(KIND_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_unit(16'h0000, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(HIGH_SURR_FIRST, 1'b0);
    send_unit(LOW_SURR_LAST, 1'b0);
    send_unit(LOW_SURR_FIRST, 1'b0);
    send_unit(HIGH_SURR_LAST, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(HIGH_SURR_FIRST, 1'b1);
    drain();

    // Flagged errors, then a stream that runs out of room.
    write_regs(24'd2, 24'd0, MODE_FLAG, 8'h00);
    send_unit(HIGH_SURR_FIRST, 1'b0);
    send_unit(LOW_SURR_FIRST, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0041, 1'b1);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    drain();

    // Initial count above capacity, fill with a zero byte.
    write_regs(24'd0, 24'hFFFFFF, MODE_FILL, 8'h00);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0000, 1'b1);
    drain();

    write_regs(24'd5, 24'd3, MODE_SPARE, 8'h5A);
    send_unit(16'h0041, 1'b0);
    send_unit(HIGH_SURR_LAST, 1'b0);
    send_unit(16'h0000, 1'b1);
    drain();

    // A replacement byte without room is dropped; a real byte overflows.
    write_regs(24'd1, 24'd0, MODE_FILL, 8'h77);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0000, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      random_setup();
      case (p / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      units = 0;
      while (units < 4) random_stream(units);
      drain();
    end

    // The receiver holds off while the sender keeps offering.
    write_regs(24'hFFFFFF, 24'd0, MODE_FILL, 8'h3C);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_seq++;
    units = 0;
    while (units < 12) random_stream(units);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
